[rtl/sarc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the socket address rule checker.
// No dependencies; imported by every module of the block.
package sarc_pkg;

  // Default table depth, handed to the top level parameter
  localparam int MAX_RULES_DEF = 32;

  localparam logic [15:0] PORT_TOP = 16'hFFFF;

  // Stream widths
  localparam int IN_TDATA_W  = 176;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_W       = 16;

  // Input tdata field offsets, lowest bit first
  localparam int OFS_KIND  = 0;
  localparam int OFS_OP    = 1;
  localparam int OFS_STYPE = 3;
  localparam int OFS_FAM   = 5;
  localparam int OFS_HI    = 7;
  localparam int OFS_LO    = 71;
  localparam int OFS_PFST  = 135;
  localparam int OFS_PLST  = 151;
  localparam int OFS_HADDR = 167;
  localparam int OFS_UNIX  = 168;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Operation codes
  localparam logic [1:0] ACC_BIND    = 2'd0;
  localparam logic [1:0] ACC_CONNECT = 2'd1;
  localparam logic [1:0] ACC_SENDMSG = 2'd2;
  localparam logic [1:0] ACC_RECVMSG = 2'd3;

  // Socket types
  localparam logic [1:0] STYPE_STREAM = 2'd0;
  localparam logic [1:0] STYPE_DGRAM  = 2'd1;

  // Address families
  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;
  localparam logic [1:0] FAM_UNIX = 2'd2;

  typedef enum logic [2:0] {
    ST_ALLOW  = 3'd0,
    ST_DENY   = 3'd1,
    ST_ADDED  = 3'd2,
    ST_BADFAM = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECIDE = 2'd1,
    S_SCAN   = 2'd2,
    S_DONE   = 2'd3
  } state_t;

  typedef struct packed {
    logic wild_port;
    logic wild_addr;
    logic peer;
    logic v6;
  } rule_tags_t;

  // One stored rule, one memory word
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port_last;
    logic [15:0] port_first;
    rule_tags_t  tags;
  } rule_entry_t;

  // Access being looked up
  typedef struct packed {
    logic        peer;
    logic        v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
  } lookup_key_t;

  typedef struct packed {
    logic        command;
    logic        rule_kind;
    logic [1:0]  operation;
    logic [1:0]  socket_type;
    logic [1:0]  addr_family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] port_first;
    logic [15:0] port_last;
    logic        has_address;
    logic        unix_name_matches;
  } item_t;

endpackage

[rtl/sarc_rule_mem.sv]
`timescale 1ns / 1ps
// Rule table: one synchronous memory, one write and one read port,
// read data registered. Uses sarc_pkg.
module sarc_rule_mem #(
  parameter int MAX_RULES = 32,
  parameter int AW        = 5
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sarc_pkg::rule_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sarc_pkg::rule_entry_t rd_data
);
  import sarc_pkg::*;

  rule_entry_t rule_mem [MAX_RULES];
  rule_entry_t rd_data_r;

  // Write the appended rule
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry per cycle while rd_en is high
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rule_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/sarc_rule_match.sv]
`timescale 1ns / 1ps
// Compare of one stored rule against the access key: kind, family,
// address and port range, with the any-address and any-port tags. Uses sarc_pkg.
module sarc_rule_match (
  input  sarc_pkg::rule_entry_t entry,
  input  sarc_pkg::lookup_key_t key,
  output logic                  hit
);
  import sarc_pkg::*;

  logic kind_ok;
  logic fam_ok;
  logic addr_ok;
  logic port_ok;

  // Rule kind and family must agree
  assign kind_ok = (entry.tags.peer == key.peer);
  assign fam_ok  = (entry.tags.v6 == key.v6);

  // Address: exact 128-bit match unless the rule takes any address
  assign addr_ok = entry.tags.wild_addr ||
                   ((entry.addr_hi == key.addr_hi) && (entry.addr_lo == key.addr_lo));

  // Port: inside the range; a reversed range holds nothing
  assign port_ok = entry.tags.wild_port ||
                   ((key.port >= entry.port_first) && (key.port <= entry.port_last));

  assign hit = kind_ok && fam_ok && addr_ok && port_ok;

endmodule

[rtl/socket_address_rule_checker_core.sv]
`timescale 1ns / 1ps
// Socket address rule checker: rule table in a registered-read synchronous memory,
// walked one entry per cycle for network checks. Uses sarc_pkg, sarc_rule_mem,
// sarc_rule_match.
// Add items and shortcut decisions go from S_DECIDE to S_DONE; a table search walks
// the N rules held in S_SCAN, one read per cycle on the single memory read port,
// until a hit or until the last entry read is compared, then moves to S_DONE.
// One item at a time; the next is taken in the cycle after the result moves to
// the output register.
// Reset (rst_n low, synchronous): rule count, multicast port and control clear.
module socket_address_rule_checker_core #(
  parameter int MAX_RULES = sarc_pkg::MAX_RULES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: mcast_port
  input  logic                             cfg_wr_en,
  input  logic [sarc_pkg::CFG_W-1:0]       cfg_wr_data,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low to high: rule_kind, operation[2], socket_type[2], addr_family[2],
  // address_high[64], address_low[64], port_first[16], port_last[16],
  // has_address, unix_name_matches, zero pad to 176
  input  logic [sarc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: command
  input  logic [sarc_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low to high: allowed, status[3], zero pad to 8
  output logic [sarc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sarc_pkg::*;

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RULES);

  state_t          state_r, state_nxt;
  item_t           item_r, item_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic            pend_r, pend_nxt;
  status_t         res_r, res_nxt;
  logic [15:0]     mcast_r, mcast_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_allowed_r, out_allowed_nxt;
  status_t         out_status_r, out_status_nxt;

  logic            in_accept;
  item_t           in_item;
  logic            is_v6;
  logic [63:0]     key_hi;
  logic [63:0]     key_lo;
  rule_entry_t     new_entry;
  lookup_key_t     key;
  logic            need_search;
  status_t         short_status;
  logic            mcast_ok;
  logic            mem_wr_en;
  logic            rd_en;
  rule_entry_t     rd_entry;
  logic            hit;
  logic            scan_hit;
  logic            scan_end;
  logic            out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Unpack the incoming beat
  always_comb begin
    in_item.command           = in_tuser[0];
    in_item.rule_kind         = in_tdata[OFS_KIND];
    in_item.operation         = in_tdata[OFS_OP +: 2];
    in_item.socket_type       = in_tdata[OFS_STYPE +: 2];
    in_item.addr_family       = in_tdata[OFS_FAM +: 2];
    in_item.address_high      = in_tdata[OFS_HI +: 64];
    in_item.address_low       = in_tdata[OFS_LO +: 64];
    in_item.port_first        = in_tdata[OFS_PFST +: 16];
    in_item.port_last         = in_tdata[OFS_PLST +: 16];
    in_item.has_address       = in_tdata[OFS_HADDR];
    in_item.unix_name_matches = in_tdata[OFS_UNIX];
  end

  // Normalise the address: IPv4 keeps only the low 32 bits
  assign is_v6  = (item_r.addr_family == FAM_IPV6);
  assign key_hi = is_v6 ? item_r.address_high : 64'd0;
  assign key_lo = is_v6 ? item_r.address_low : {32'd0, item_r.address_low[31:0]};

  // Rule to append on an add
  always_comb begin
    new_entry.addr_hi        = key_hi;
    new_entry.addr_lo        = key_lo;
    new_entry.port_first     = item_r.port_first;
    new_entry.port_last      = item_r.port_last;
    new_entry.tags.v6        = is_v6;
    new_entry.tags.peer      = item_r.rule_kind;
    new_entry.tags.wild_addr = (key_hi == 64'd0) && (key_lo == 64'd0);
    new_entry.tags.wild_port = (item_r.port_first == 16'd0) && (item_r.port_last == PORT_TOP);
  end

  // Search key: only bind looks at bind rules
  always_comb begin
    key.peer    = (item_r.operation != ACC_BIND);
    key.v6      = is_v6;
    key.addr_hi = key_hi;
    key.addr_lo = key_lo;
    key.port    = item_r.port_first;
  end

  // Shortcut decisions that need no table walk
  always_comb begin
    need_search  = 1'b0;
    short_status = ST_DENY;
    if ((item_r.operation == ACC_BIND) || (item_r.operation == ACC_CONNECT)) begin
      if (item_r.addr_family == FAM_UNIX) begin
        short_status = ((item_r.socket_type == STYPE_STREAM) && item_r.unix_name_matches)
                       ? ST_ALLOW : ST_DENY;
      end else if ((item_r.socket_type > STYPE_DGRAM) || (item_r.addr_family > FAM_IPV6)) begin
        short_status = ST_DENY;
      end else begin
        need_search = 1'b1;
      end
    end else if ((item_r.addr_family == FAM_UNIX) || (item_r.socket_type == STYPE_STREAM)) begin
      short_status = ST_ALLOW;
    end else if ((item_r.operation == ACC_SENDMSG) && !item_r.has_address) begin
      short_status = ST_ALLOW;
    end else if ((item_r.socket_type > STYPE_DGRAM) || (item_r.addr_family > FAM_IPV6)) begin
      short_status = ST_DENY;
    end else if (item_r.operation == ACC_RECVMSG) begin
      short_status = ST_ALLOW;
    end else begin
      need_search = 1'b1;
    end
  end

  assign mcast_ok = (mcast_r != 16'd0) && (item_r.addr_family == FAM_IPV4) &&
                    (item_r.port_first == mcast_r);

  // Scan ends on a hit in the entry just read, or once every entry is compared
  assign scan_hit = pend_r && hit;
  assign scan_end = scan_hit || (iss_r == count_r);

  sarc_rule_mem #(
    .MAX_RULES (MAX_RULES),
    .AW        (AW)
  ) u_rule_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (new_entry),
    .rd_en   (rd_en),
    .rd_addr (iss_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  sarc_rule_match u_rule_match (
    .entry (rd_entry),
    .key   (key),
    .hit   (hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if ((item_r.command == CMD_CHECK) && need_search) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    item_nxt        = in_accept ? in_item : item_r;
    mcast_nxt       = cfg_wr_en ? cfg_wr_data : mcast_r;
    count_nxt       = count_r;
    iss_nxt         = iss_r;
    pend_nxt        = pend_r;
    res_nxt         = res_r;
    mem_wr_en       = 1'b0;
    rd_en           = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_allowed_nxt = out_allowed_r;
    out_status_nxt  = out_status_r;
    case (state_r)
      S_DECIDE: begin
        if (item_r.command == CMD_ADD) begin
          if (item_r.addr_family > FAM_IPV6) begin
            res_nxt = ST_BADFAM;
          end else if (count_r >= CNT_MAX) begin
            res_nxt = ST_FULL;
          end else begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + 1'b1;
            res_nxt   = ST_ADDED;
          end
        end else if (need_search) begin
          iss_nxt  = '0;
          pend_nxt = 1'b0;
        end else begin
          res_nxt = short_status;
        end
      end
      S_SCAN: begin
        // Issue the next read while the previous entry is compared
        rd_en    = (iss_r < count_r) && !scan_hit;
        pend_nxt = rd_en;
        if (rd_en) iss_nxt = iss_r + 1'b1;
        if (scan_hit) res_nxt = ST_ALLOW;
        else if (scan_end) res_nxt = mcast_ok ? ST_ALLOW : ST_DENY;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = (res_r == ST_ALLOW);
          out_status_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mcast_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mcast_r     <= mcast_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      iss_r       <= iss_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    res_r         <= res_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_status_r, out_allowed_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("rule count beyond table depth");

  a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (count_r < CNT_MAX) && (state_r == S_DECIDE))
    else $error("rule written into a full table");

  a_hit_allows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r && hit) |=> (state_r == S_DONE) && (res_r == ST_ALLOW))
    else $error("matching rule did not allow the access");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside the done state");

endmodule

[sim/sarc_verdict_monitor.sv]
`timescale 1ns / 1ps
// Watches the rule checker's input, result and mcast_port write ports, predicts
// the status of every accepted item and compares it with each result beat.
// Depends on sarc_pkg for field offsets, codes and the stored-rule layout.
module sarc_verdict_monitor #(
  parameter int MAX_RULES = sarc_pkg::MAX_RULES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sarc_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sarc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [sarc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sarc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               outstanding
);
  import sarc_pkg::*;

  typedef struct {
    logic    allowed;
    status_t status;
  } verdict_t;

  verdict_t    verdict_q[$];
  rule_entry_t rules[MAX_RULES];
  int unsigned rules_held;
  logic [15:0] mcast_now;
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // Walk the held rules in order; first match of kind, family, address and port wins
  function automatic status_t search_rules(input logic peer, input logic [1:0] fam,
                                           input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [15:0] dst_port);
    rule_entry_t r;
    if (fam == FAM_IPV4) begin
      hi = '0;
      lo = {32'd0, lo[31:0]};
    end
    for (int i = 0; i < int'(rules_held); i++) begin
      r = rules[i];
      if (r.tags.peer != peer) continue;
      if (r.tags.v6 != (fam == FAM_IPV6)) continue;
      if (!r.tags.wild_addr && (r.addr_hi != hi || r.addr_lo != lo)) continue;
      if (!r.tags.wild_port && (dst_port < r.port_first || dst_port > r.port_last)) continue;
      return ST_ALLOW;
    end
    // IPv4 multicast port exception, disabled by a zero port
    if (mcast_now != '0 && fam == FAM_IPV4 && dst_port == mcast_now) return ST_ALLOW;
    return ST_DENY;
  endfunction

  // Work out the result of one item; an add also updates the rule store
  function automatic verdict_t predict_verdict(input item_t it);
    verdict_t    v;
    rule_entry_t e;
    logic        net_fam;
    logic        sock_other;
    net_fam    = (it.addr_family == FAM_IPV4 || it.addr_family == FAM_IPV6);
    sock_other = !(it.socket_type == STYPE_STREAM || it.socket_type == STYPE_DGRAM);
    v.allowed  = 1'b0;
    if (it.command == CMD_ADD) begin
      if (!net_fam) begin
        v.status = ST_BADFAM;
      end else if (rules_held >= MAX_RULES) begin
        v.status = ST_FULL;
      end else begin
        e.tags.v6        = (it.addr_family == FAM_IPV6);
        e.tags.peer      = it.rule_kind;
        e.addr_hi        = e.tags.v6 ? it.address_high : 64'd0;
        e.addr_lo        = e.tags.v6 ? it.address_low : {32'd0, it.address_low[31:0]};
        e.tags.wild_addr = (e.addr_hi == '0 && e.addr_lo == '0);
        e.tags.wild_port = (it.port_first == '0 && it.port_last == PORT_TOP);
        e.port_first     = it.port_first;
        e.port_last      = it.port_last;
        rules[rules_held] = e;
        rules_held++;
        v.status = ST_ADDED;
      end
      return v;
    end
    if (it.operation == ACC_BIND || it.operation == ACC_CONNECT) begin
      if (it.addr_family == FAM_UNIX)
        v.status = (it.socket_type == STYPE_STREAM && it.unix_name_matches) ? ST_ALLOW : ST_DENY;
      else if (sock_other || !net_fam)
        v.status = ST_DENY;
      else
        v.status = search_rules(it.operation == ACC_CONNECT, it.addr_family,
                                it.address_high, it.address_low, it.port_first);
    end else if (it.addr_family == FAM_UNIX || it.socket_type == STYPE_STREAM) begin
      v.status = ST_ALLOW;
    end else if (it.operation == ACC_SENDMSG && !it.has_address) begin
      v.status = ST_ALLOW;
    end else if (sock_other || !net_fam) begin
      v.status = ST_DENY;
    end else if (it.operation == ACC_RECVMSG) begin
      v.status = ST_ALLOW;
    end else begin
      v.status = search_rules(1'b1, it.addr_family, it.address_high, it.address_low,
                              it.port_first);
    end
    v.allowed = (v.status == ST_ALLOW);
    return v;
  endfunction

  // Compare result beats first, then queue the prediction for a new input beat
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    item_t    it;
    if (!rst_n) begin
      verdict_q.delete();
      rules_held = 0;
      mcast_now  = '0;
    end else begin
      if (cfg_wr_en) mcast_now = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.allowed = out_tdata[0];
        got.status  = status_t'(out_tdata[3:1]);
        if (verdict_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, status", int'(got.status), -1);
        end else begin
          want = verdict_q.pop_front();
          if (got.allowed !== want.allowed)
            report_mismatch("allowed", int'(got.allowed), int'(want.allowed));
          if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        end
      end
      if (in_tvalid && in_tready) begin
        it.command           = in_tuser[0];
        it.rule_kind         = in_tdata[OFS_KIND];
        it.operation         = in_tdata[OFS_OP +: 2];
        it.socket_type       = in_tdata[OFS_STYPE +: 2];
        it.addr_family       = in_tdata[OFS_FAM +: 2];
        it.address_high      = in_tdata[OFS_HI +: 64];
        it.address_low       = in_tdata[OFS_LO +: 64];
        it.port_first        = in_tdata[OFS_PFST +: 16];
        it.port_last         = in_tdata[OFS_PLST +: 16];
        it.has_address       = in_tdata[OFS_HADDR];
        it.unix_name_matches = in_tdata[OFS_UNIX];
        verdict_q.push_back(predict_verdict(it));
      end
    end
    outstanding <= verdict_q.size();
  end

endmodule

[sim/tb_socket_address_rule_checker_core.sv]
`timescale 1ns / 1ps
// Testbench top for the socket address rule checker: drives rule adds and
// access checks under varied idling, sets mcast_port, and gives the verdict.
// Depends on sarc_pkg, the block under test and sarc_verdict_monitor.
module tb_socket_address_rule_checker_core;
  import sarc_pkg::*;

  localparam int MAX_RULES       = MAX_RULES_DEF;
  localparam int ITEMS_PER_PHASE = 385;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1_000_000;

  localparam logic       KIND_BIND    = 1'b0;
  localparam logic       KIND_PEER    = 1'b1;
  localparam logic [1:0] FAM_OTHER    = 2'd3;
  localparam logic [1:0] STYPE_OTHER  = 2'd2;
  localparam logic [1:0] STYPE_OTHER3 = 2'd3;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int          fail_count;
  int          outstanding;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        hold_req     = 1'b0;
  int          hold_cnt     = 0;
  logic [15:0] mcast_now    = '0;

  logic [31:0] v4_pool[8];
  logic [63:0] v6_hi_pool[8];
  logic [63:0] v6_lo_pool[8];
  logic [15:0] port_pool[8] = '{16'd0, 16'd1, 16'd80, 16'd443, 16'd1024, 16'd5353,
                                16'd8080, 16'd65535};
  int          tx_pct_by_phase[4] = '{0, 47, 0, 22};
  int          rx_pct_by_phase[4] = '{0, 0, 47, 22};

  socket_address_rule_checker_core #(.MAX_RULES(MAX_RULES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sarc_verdict_monitor #(.MAX_RULES(MAX_RULES)) monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Give up on a hung run
  initial begin
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("socket_address_rule_checker_core regression: fail");
    $finish;
  end

  function automatic item_t mk(input logic cmd, input logic kind, input logic [1:0] op,
                               input logic [1:0] stype, input logic [1:0] fam,
                               input logic [63:0] hi, input logic [63:0] lo,
                               input logic [15:0] pf, input logic [15:0] pl,
                               input logic ha, input logic ux);
    item_t it;
    it.command           = cmd;
    it.rule_kind         = kind;
    it.operation         = op;
    it.socket_type       = stype;
    it.addr_family       = fam;
    it.address_high      = hi;
    it.address_low       = lo;
    it.port_first        = pf;
    it.port_last         = pl;
    it.has_address       = ha;
    it.unix_name_matches = ux;
    return it;
  endfunction

  // Random item: mostly checks against pooled addresses and ports so rules hit
  function automatic item_t random_item();
    item_t it;
    int    r;
    int    k;
    int    span_end;
    it.command   = ($urandom_range(99) < 9) ? CMD_ADD : CMD_CHECK;
    it.rule_kind = 1'($urandom_range(1));
    it.operation = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 25)      it.socket_type = STYPE_STREAM;
    else if (r < 75) it.socket_type = STYPE_DGRAM;
    else             it.socket_type = ($urandom_range(1) != 0) ? STYPE_OTHER : STYPE_OTHER3;
    r = $urandom_range(99);
    if (r < 42)      it.addr_family = FAM_IPV4;
    else if (r < 84) it.addr_family = FAM_IPV6;
    else if (r < 92) it.addr_family = FAM_UNIX;
    else             it.addr_family = FAM_OTHER;
    k = $urandom_range(7);
    r = $urandom_range(99);
    if (r < 75) begin
      if (it.addr_family == FAM_IPV6) begin
        it.address_high = v6_hi_pool[k];
        it.address_low  = v6_lo_pool[k];
      end else begin
        // upper bits are junk that an IPv4 compare must ignore
        it.address_high = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        it.address_low  = {(($urandom_range(3) == 0) ? $urandom : 32'd0), v4_pool[k]};
      end
    end else if (r < 85) begin
      it.address_high = '0;
      it.address_low  = '0;
    end else if (r < 90) begin
      it.address_high = '1;
      it.address_low  = '1;
    end else begin
      it.address_high = {$urandom, $urandom};
      it.address_low  = {$urandom, $urandom};
    end
    r = $urandom_range(99);
    if (it.command == CMD_ADD && r < 10) begin
      it.port_first = '0;
      it.port_last  = PORT_TOP;
    end else begin
      if (r < 70)
        it.port_first = ($urandom_range(4) == 0) ? mcast_now : port_pool[$urandom_range(7)];
      else
        it.port_first = 16'($urandom);
      if ($urandom_range(99) < 10) begin
        it.port_last = 16'($urandom);
      end else begin
        span_end     = int'(it.port_first) + $urandom_range(63);
        it.port_last = (span_end > int'(PORT_TOP)) ? PORT_TOP : 16'(span_end);
      end
    end
    it.has_address       = 1'($urandom_range(1));
    it.unix_name_matches = 1'($urandom_range(1));
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_item(input item_t it);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[OFS_KIND]       = it.rule_kind;
    beat[OFS_OP +: 2]    = it.operation;
    beat[OFS_STYPE +: 2] = it.socket_type;
    beat[OFS_FAM +: 2]   = it.addr_family;
    beat[OFS_HI +: 64]   = it.address_high;
    beat[OFS_LO +: 64]   = it.address_low;
    beat[OFS_PFST +: 16] = it.port_first;
    beat[OFS_PLST +: 16] = it.port_last;
    beat[OFS_HADDR]      = it.has_address;
    beat[OFS_UNIX]       = it.unix_name_matches;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    in_tuser  <= it.command;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mcast(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    mcast_now    = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      v4_pool[i]    = $urandom;
      v6_hi_pool[i] = {$urandom, $urandom};
      v6_lo_pool[i] = {$urandom, $urandom};
    end
    v4_pool[0]    = 32'hC0A8_0001;
    v4_pool[1]    = 32'h0A00_0002;
    v6_hi_pool[0] = 64'h2001_0DB8_0000_0000;
    v6_lo_pool[0] = 64'h0000_0000_0000_0001;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mcast(16'd5353);

    // Directed rules: exact port, ignored IPv4 upper bits, any address, any port,
    // reversed range, then adds with Unix and other families
    send_item(mk(CMD_ADD, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_C0A8_0001, 16'd80, 16'd80, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_PEER, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'hDEAD_BEEF_0000_0001,
                 64'hFFFF_0000_0A00_0002, 16'd1000, 16'd2000, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_PEER, ACC_CONNECT, STYPE_DGRAM, FAM_IPV6, 64'd0, 64'd0,
                 16'd443, 16'd443, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_BIND, ACC_BIND, STYPE_STREAM, FAM_IPV6, 64'h2001_0DB8_0000_0000,
                 64'h0000_0000_0000_0001, 16'd0, PORT_TOP, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_PEER, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_0A00_0003, 16'd3000, 16'd2000, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_IPV4, '1,
                 64'hABCD_0000_0000_0000, PORT_TOP, PORT_TOP, 1'b0, 1'b0));
    send_item(mk(CMD_ADD, KIND_PEER, ACC_BIND, STYPE_DGRAM, FAM_UNIX, 64'd1, 64'd1,
                 16'd1, 16'd2, 1'b0, 1'b1));
    send_item(mk(CMD_ADD, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_OTHER, 64'd1, 64'd1,
                 16'd1, 16'd2, 1'b0, 1'b0));

    // Directed checks: table hits and misses, multicast exception, shortcuts
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_C0A8_0001, 16'd80, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_C0A8_0001, 16'd81, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_IPV4,
                 64'h0123_4567_89AB_CDEF, 64'h1234_5678_0A00_0002, 16'd1500, 16'd0,
                 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_0A00_0003, 16'd2500, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_IPV6, {$urandom, $urandom},
                 {$urandom, $urandom}, 16'd443, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_STREAM, FAM_IPV6, 64'h2001_0DB8_0000_0000,
                 64'h0000_0000_0000_0001, 16'd12345, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_0808_0808, PORT_TOP, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_0808_0808, 16'd5353, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_IPV6,
                 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0001, 16'd5353, 16'd0,
                 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_STREAM, FAM_UNIX, 64'd0, 64'd0,
                 16'd0, 16'd0, 1'b0, 1'b1));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_CONNECT, STYPE_DGRAM, FAM_UNIX, 64'd0, 64'd0,
                 16'd0, 16'd0, 1'b0, 1'b1));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_SENDMSG, STYPE_OTHER, FAM_UNIX, 64'd0, 64'd0,
                 16'd0, 16'd0, 1'b1, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_RECVMSG, STYPE_STREAM, FAM_IPV4, 64'd0, 64'd7,
                 16'd9, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_SENDMSG, STYPE_DGRAM, FAM_IPV4, 64'd0, 64'd7,
                 16'd9, 16'd0, 1'b0, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_SENDMSG, STYPE_DGRAM, FAM_OTHER, 64'd0, 64'd7,
                 16'd9, 16'd0, 1'b1, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_RECVMSG, STYPE_OTHER3, FAM_IPV4, 64'd0, 64'd7,
                 16'd9, 16'd0, 1'b1, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_RECVMSG, STYPE_DGRAM, FAM_IPV6, 64'd3, 64'd7,
                 16'd9, 16'd0, 1'b1, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_SENDMSG, STYPE_DGRAM, FAM_IPV4, 64'd0,
                 64'h0000_0000_0A00_0002, 16'd1500, 16'd0, 1'b1, 1'b0));
    send_item(mk(CMD_CHECK, KIND_BIND, ACC_BIND, STYPE_STREAM, FAM_OTHER, 64'd0, 64'd7,
                 16'd80, 16'd0, 1'b0, 1'b1));

    // Random phases, each with its own multicast port and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       write_mcast(PORT_TOP);
        1:       write_mcast(16'd0);
        2:       write_mcast(16'($urandom_range(1, 65534)));
        default: write_mcast(16'd5353);
      endcase
      tx_idle_pct   = tx_pct_by_phase[ph];
      rx_stall_pct <= rx_pct_by_phase[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result hold-off while the sender keeps offering
        if (ph == 0 && n == 40) hold_req <= 1'b1;
        if (n == 200) wait_idle();
        send_item(random_item());
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("socket_address_rule_checker_core regression: pass");
    end else begin
      $display("socket_address_rule_checker_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sarc_pkg.sv
rtl/sarc_rule_mem.sv
rtl/sarc_rule_match.sv
rtl/socket_address_rule_checker_core.sv
sim/sarc_verdict_monitor.sv
sim/tb_socket_address_rule_checker_core.sv
